// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the byte ring FIFO datapath.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BRF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define BRF_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/brf_pkg.sv =====
// ---------------------------------------------------------------------------
// brf_pkg
// Widths, defaults and the controller/datapath interface types of the
// byte ring FIFO.
// ---------------------------------------------------------------------------
package brf_pkg;

  localparam int BYTE_W          = 8;
  localparam int REQ_W           = 7;
  localparam int LEVEL_W         = 10;
  localparam int RING_SIZE_W     = 11;
  localparam int RING_SIZE_RESET = 1024;
  localparam int MIN_RING_SIZE   = 2;

  localparam int DEF_STORE_DEPTH = 1024;
  localparam int DEF_MAX_BURST   = 64;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_item;   // write item: store the byte unless full, report
    logic empty_rd;  // read item with nothing to deliver
    logic rd;        // read one byte from the ring and report it
    logic load;      // first byte of a burst: load the remaining count
    logic last;      // this read is the final word of the burst
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic cnt_zero;
    logic cnt_one;
    logic rem_one;
  } status_t;

endpackage

// ===== rtl/core/brf_ctrl.sv =====
// ---------------------------------------------------------------------------
// brf_ctrl
// Controller of the byte ring FIFO: accepts items and sequences read bursts.
// ---------------------------------------------------------------------------
module brf_ctrl import brf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    op,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_BURST = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (op == OP_WRITE) begin
            cmd.wr_item = 1'b1;
          end else if (status.cnt_zero) begin
            cmd.empty_rd = 1'b1;
          end else begin
            // The first byte is read in the accept cycle itself.
            cmd.rd   = 1'b1;
            cmd.load = 1'b1;
            cmd.last = status.cnt_one;
            if (!status.cnt_one) begin
              state_next = ST_BURST;
            end
          end
        end
      end
      ST_BURST: begin
        cmd.rd   = 1'b1;
        cmd.last = status.rem_one;
        if (status.rem_one) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state == ST_BURST);

endmodule

// ===== rtl/core/brf_datapath.sv =====
// ---------------------------------------------------------------------------
// brf_datapath
// Byte store, ring positions, fill count, burst counter and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_datapath import brf_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_BURST   = DEF_MAX_BURST
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ring_size_we,
  input  logic [RING_SIZE_W-1:0] ring_size,
  input  logic [BYTE_W-1:0]      write_byte,
  input  logic [REQ_W-1:0]       request_count,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [BYTE_W-1:0]      read_byte,
  output logic                   byte_valid,
  output logic                   accepted,
  output logic                   last,
  output logic [LEVEL_W-1:0]     fill_level,
  output logic                   result_strobe
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int SZ_W  = $clog2(STORE_DEPTH + 1);
  localparam int CFG_W = (SZ_W > RING_SIZE_W) ? SZ_W : RING_SIZE_W;
  localparam int CW    = (PTR_W > REQ_W) ? PTR_W : REQ_W;
  localparam int FW    = (PTR_W > LEVEL_W) ? PTR_W : LEVEL_W;
  localparam int RST_SIZE = (RING_SIZE_RESET > STORE_DEPTH) ? STORE_DEPTH : RING_SIZE_RESET;

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic [SZ_W-1:0]   size;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  fill;
  logic [REQ_W-1:0]  rem;

  logic              valid_r;
  logic              acc_r;
  logic              last_r;
  logic [PTR_W-1:0]  lvl_r;

  logic [SZ_W-1:0]   size_next;
  logic [CFG_W-1:0]  cfg_ext;
  logic [SZ_W-1:0]   wp_inc;
  logic [SZ_W-1:0]   rp_inc;
  logic [PTR_W-1:0]  wp_next;
  logic [PTR_W-1:0]  rp_next;
  logic [REQ_W-1:0]  req_c;
  logic [REQ_W-1:0]  cnt;
  logic [FW-1:0]     lvl_wide;

  // Out-of-range ring sizes act as the nearest legal size.
  always_comb begin
    cfg_ext = CFG_W'(ring_size);
    if (cfg_ext < CFG_W'(MIN_RING_SIZE)) begin
      size_next = SZ_W'(MIN_RING_SIZE);
    end else if (cfg_ext > CFG_W'(STORE_DEPTH)) begin
      size_next = SZ_W'(STORE_DEPTH);
    end else begin
      size_next = SZ_W'(cfg_ext);
    end
  end

  // Positions wrap by compare against the configured size.
  assign wp_inc  = SZ_W'(wp) + SZ_W'(1);
  assign rp_inc  = SZ_W'(rp) + SZ_W'(1);
  assign wp_next = (wp_inc >= size) ? '0 : PTR_W'(wp_inc);
  assign rp_next = (rp_inc >= size) ? '0 : PTR_W'(rp_inc);

  assign req_c = (request_count > REQ_W'(MAX_BURST)) ? REQ_W'(MAX_BURST) : request_count;
  assign cnt   = (CW'(fill) < CW'(req_c)) ? REQ_W'(fill) : req_c;

  assign status.full     = (SZ_W'(fill) == size - SZ_W'(1));
  assign status.cnt_zero = (cnt == '0);
  assign status.cnt_one  = (cnt == REQ_W'(1));
  assign status.rem_one  = (rem == REQ_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.wr_item && !status.full) begin
      mem[wp] <= write_byte;
    end
    if (cmd.rd) begin
      rdata <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size          <= SZ_W'(RST_SIZE);
      rp            <= '0;
      wp            <= '0;
      fill          <= '0;
      rem           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.wr_item || cmd.empty_rd || cmd.rd;
      if (ring_size_we) begin
        size <= size_next;
        rp   <= '0;
        wp   <= '0;
        fill <= '0;
      end else if (cmd.wr_item) begin
        if (!status.full) begin
          wp   <= wp_next;
          fill <= fill + PTR_W'(1);
        end
      end else if (cmd.rd) begin
        rp   <= rp_next;
        fill <= fill - PTR_W'(1);
        rem  <= cmd.load ? (cnt - REQ_W'(1)) : (rem - REQ_W'(1));
      end
    end
  end

  // Result fields; only meaningful while the strobe is high.
  always_ff @(posedge clk) begin
    if (cmd.wr_item) begin
      valid_r <= 1'b0;
      acc_r   <= !status.full;
      last_r  <= 1'b1;
      lvl_r   <= status.full ? fill : (fill + PTR_W'(1));
    end else if (cmd.empty_rd) begin
      valid_r <= 1'b0;
      acc_r   <= 1'b0;
      last_r  <= 1'b1;
      lvl_r   <= fill;
    end else if (cmd.rd) begin
      valid_r <= 1'b1;
      acc_r   <= 1'b0;
      last_r  <= cmd.last;
      lvl_r   <= fill - PTR_W'(1);
    end
  end

  assign lvl_wide   = FW'(lvl_r);
  assign fill_level = lvl_wide[LEVEL_W-1:0];
  assign read_byte  = valid_r ? rdata : '0;
  assign byte_valid = valid_r;
  assign accepted   = acc_r;
  assign last       = last_r;

  `BRF_ASSERT(a_fill_below_size, clk, rst, SZ_W'(fill) < size, "fill count reached ring size")
  `BRF_ASSERT_NEVER(a_read_when_empty, clk, rst, cmd.rd && (fill == '0), "read issued on empty ring")
  `BRF_ASSERT(a_write_result, clk, rst, cmd.wr_item |=> result_strobe && !valid_r && last_r, "write item gave no single result")

endmodule

// ===== rtl/core/byte_ring_fifo.sv =====
// Every result is registered and shows in the cycle after the edge that issued it.
// Write items never raise busy, so writes can follow back to back.
// A read item of n bytes (n >= 1) holds busy after acceptance while the bytes after
// the first are read, one byte per cycle, set by the single read port of the byte store.
// Reset empties the ring and sets the ring size to its default; the store is
// not cleared. Results are strobed for one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
// byte_ring_fifo
// Byte FIFO in a circular store of configurable size, one slot kept empty.
// ---------------------------------------------------------------------------
module byte_ring_fifo import brf_pkg::*; #(
  parameter int STORE_DEPTH = DEF_STORE_DEPTH,
  parameter int MAX_BURST   = DEF_MAX_BURST
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ring_size_we,
  input  logic [RING_SIZE_W-1:0] ring_size,
  input  logic                   start,
  output logic                   busy,
  input  logic                   op,
  input  logic [BYTE_W-1:0]      write_byte,
  input  logic [REQ_W-1:0]       request_count,
  output logic                   result_strobe,
  output logic [BYTE_W-1:0]      read_byte,
  output logic                   byte_valid,
  output logic                   accepted,
  output logic                   last,
  output logic [LEVEL_W-1:0]     fill_level
);

  cmd_t    cmd;
  status_t status;

  brf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  brf_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_BURST   (MAX_BURST)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ring_size_we  (ring_size_we),
    .ring_size     (ring_size),
    .write_byte    (write_byte),
    .request_count (request_count),
    .cmd           (cmd),
    .status        (status),
    .read_byte     (read_byte),
    .byte_valid    (byte_valid),
    .accepted      (accepted),
    .last          (last),
    .fill_level    (fill_level),
    .result_strobe (result_strobe)
  );

endmodule

// ===== tb/brf_result_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// brf_result_checker
// Watches the command, configuration and result ports of the byte ring FIFO.
// It keeps its own copy of the ring, works out the result words of each
// accepted command and compares every strobed word with the oldest one due.
// ---------------------------------------------------------------------------
module brf_result_checker import brf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ring_size_we,
  input  logic [RING_SIZE_W-1:0] ring_size,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   op,
  input  logic [BYTE_W-1:0]      write_byte,
  input  logic [REQ_W-1:0]       request_count,
  input  logic                   result_strobe,
  input  logic [BYTE_W-1:0]      read_byte,
  input  logic                   byte_valid,
  input  logic                   accepted,
  input  logic                   last,
  input  logic [LEVEL_W-1:0]     fill_level,
  output int                     mismatch_count,
  output int                     pending_words
);

  localparam int STORE_DEPTH = DEF_STORE_DEPTH;
  localparam int MAX_BURST   = DEF_MAX_BURST;
  localparam int POS_W       = $clog2(STORE_DEPTH);
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_byte;
    logic               byte_valid;
    logic               accepted;
    logic               last;
    logic [LEVEL_W-1:0] fill_level;
  } fifo_word_t;

  logic [BYTE_W-1:0]      ring_bytes [STORE_DEPTH];
  int unsigned            head_pos;
  int unsigned            tail_pos;
  logic [RING_SIZE_W-1:0] size_setting;
  fifo_word_t             due_words [$];

  // Out-of-range settings are pulled back into 2 .. STORE_DEPTH.
  function automatic int unsigned used_slots();
    int unsigned slots;
    slots = 32'(size_setting);
    if (slots < MIN_RING_SIZE) slots = MIN_RING_SIZE;
    if (slots > STORE_DEPTH) slots = STORE_DEPTH;
    return slots;
  endfunction

  function automatic int unsigned next_slot(int unsigned pos, int unsigned slots);
    return (pos + 1 >= slots) ? 0 : pos + 1;
  endfunction

  function automatic int unsigned held_bytes(int unsigned slots);
    if (head_pos < tail_pos) return tail_pos - head_pos;
    if (head_pos > tail_pos) return slots - head_pos + tail_pos;
    return 0;
  endfunction

  task automatic predict_words(input logic item_op, input logic [BYTE_W-1:0] data,
                               input logic [REQ_W-1:0] req);
    int unsigned slots;
    int unsigned nxt;
    int unsigned want;
    int unsigned avail;
    int unsigned n;
    fifo_word_t  w;
    slots = used_slots();
    w     = '0;
    if (item_op == OP_WRITE) begin
      nxt = next_slot(tail_pos, slots);
      // A full ring drops the byte and leaves everything as it was.
      if (nxt != head_pos) begin
        ring_bytes[tail_pos[POS_W-1:0]] = data;
        tail_pos                        = nxt;
        w.accepted                      = 1'b1;
      end
      w.last       = 1'b1;
      w.fill_level = LEVEL_W'(held_bytes(slots));
      due_words.push_back(w);
    end else begin
      want  = (32'(req) > MAX_BURST) ? MAX_BURST : 32'(req);
      avail = held_bytes(slots);
      n     = (avail < want) ? avail : want;
      if (n == 0) begin
        w.last       = 1'b1;
        w.fill_level = LEVEL_W'(avail);
        due_words.push_back(w);
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          w.read_byte  = ring_bytes[head_pos[POS_W-1:0]];
          w.byte_valid = 1'b1;
          head_pos     = next_slot(head_pos, slots);
          w.last       = (i + 1 == n);
          w.fill_level = LEVEL_W'(held_bytes(slots));
          due_words.push_back(w);
        end
      end
    end
  endtask

  task automatic compare_word(input fifo_word_t seen);
    fifo_word_t want;
    logic       bad;
    if (due_words.size() == 0) begin
      if (mismatch_count < REPORT_MAX)
        $display("%0t: unexpected word byte=%02h valid=%0b acc=%0b last=%0b level=%0d",
                 $realtime, seen.read_byte, seen.byte_valid, seen.accepted, seen.last,
                 seen.fill_level);
      mismatch_count++;
    end else begin
      want = due_words.pop_front();
      bad  = (seen.read_byte !== want.read_byte) || (seen.byte_valid !== want.byte_valid) ||
             (seen.accepted !== want.accepted) || (seen.last !== want.last) ||
             (seen.fill_level !== want.fill_level);
      if (bad) begin
        if (mismatch_count < REPORT_MAX) begin
          $display("%0t: word mismatch", $realtime);
          $display("  expected byte=%02h valid=%0b acc=%0b last=%0b level=%0d",
                   want.read_byte, want.byte_valid, want.accepted, want.last,
                   want.fill_level);
          $display("  actual   byte=%02h valid=%0b acc=%0b last=%0b level=%0d",
                   seen.read_byte, seen.byte_valid, seen.accepted, seen.last,
                   seen.fill_level);
        end
        mismatch_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_pos       = 0;
      tail_pos       = 0;
      size_setting   = RING_SIZE_W'(RING_SIZE_RESET);
      mismatch_count = 0;
      due_words.delete();
    end else begin
      // A word strobed at this edge always belongs to an earlier command, so
      // it is checked before any command accepted at the same edge.
      if (result_strobe)
        compare_word({read_byte, byte_valid, accepted, last, fill_level});
      if (ring_size_we) begin
        size_setting = ring_size;
        head_pos     = 0;
        tail_pos     = 0;
      end
      if (start && !busy) predict_words(op, write_byte, request_count);
    end
    pending_words = due_words.size();
  end

endmodule

// ===== tb/tb_byte_ring_fifo.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_byte_ring_fifo
// Drives write and read commands into the byte ring FIFO through several
// ring sizes, the extremes among them, first a directed set and then random
// fill and drain bursts under varying sender gaps. A checker module beside
// the block predicts every result word and counts the mismatches.
// ---------------------------------------------------------------------------
module tb_byte_ring_fifo;
  import brf_pkg::*;

  localparam int   IDLE_LIMIT = 1000;
  localparam int   PHASE_LEN  = 60;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   ring_size_we  = 1'b0;
  logic [RING_SIZE_W-1:0] ring_size     = '0;
  logic                   start         = 1'b0;
  logic                   op            = OP_WRITE;
  logic [BYTE_W-1:0]      write_byte    = '0;
  logic [REQ_W-1:0]       request_count = '0;
  logic                   busy;
  logic                   result_strobe;
  logic [BYTE_W-1:0]      read_byte;
  logic                   byte_valid;
  logic                   accepted;
  logic                   last;
  logic [LEVEL_W-1:0]     fill_level;

  int mismatch_count;
  int pending_words;
  int idle_pct     = 0;
  int stall_cycles = 0;

  always #1 clk = ~clk;

  byte_ring_fifo i_dut (
    .clk          (clk),
    .rst          (rst),
    .ring_size_we (ring_size_we),
    .ring_size    (ring_size),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .write_byte   (write_byte),
    .request_count(request_count),
    .result_strobe(result_strobe),
    .read_byte    (read_byte),
    .byte_valid   (byte_valid),
    .accepted     (accepted),
    .last         (last),
    .fill_level   (fill_level)
  );

  brf_result_checker i_result_checker (
    .clk           (clk),
    .rst           (rst),
    .ring_size_we  (ring_size_we),
    .ring_size     (ring_size),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .write_byte    (write_byte),
    .request_count (request_count),
    .result_strobe (result_strobe),
    .read_byte     (read_byte),
    .byte_valid    (byte_valid),
    .accepted      (accepted),
    .last          (last),
    .fill_level    (fill_level),
    .mismatch_count(mismatch_count),
    .pending_words (pending_words)
  );

  // Any accepted command, word or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_strobe || ring_size_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == IDLE_LIMIT) begin
      $display("tb_byte_ring_fifo: FAIL");
      $finish;
    end
  end

  task automatic send_word(input logic w_op, input logic [BYTE_W-1:0] w_byte,
                           input logic [REQ_W-1:0] w_count);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    op            <= w_op;
    write_byte    <= w_byte;
    request_count <= w_count;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Every command yields at least one word, so an empty queue means idle;
  // the short pause covers the registered results.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_ring_size(input logic [RING_SIZE_W-1:0] value);
    wait_drained();
    ring_size_we <= 1'b1;
    ring_size    <= value;
    @(negedge clk);
    ring_size_we <= 1'b0;
  endtask

  function automatic logic [REQ_W-1:0] burst_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 75) return REQ_W'($urandom_range(16, 1));
    if (pick < 90) return REQ_W'($urandom_range(64, 17));
    return REQ_W'($urandom_range(127, 65));
  endfunction

  // Alternating chunks lean toward filling the ring and toward draining it.
  task automatic run_phase(input int pct, input logic [RING_SIZE_W-1:0] size);
    logic             filling;
    logic [REQ_W-1:0] cnt;
    set_ring_size(size);
    idle_pct = pct;
    for (int i = 0; i < PHASE_LEN; i++) begin
      filling = ((i / 16) % 2) == 0;
      if ($urandom_range(99) < (filling ? 80 : 35)) begin
        send_word(OP_WRITE, BYTE_W'($urandom_range(255)), REQ_W'($urandom_range(127)));
      end else begin
        cnt = filling ? REQ_W'($urandom_range(3)) : burst_count();
        send_word(OP_READ, BYTE_W'($urandom_range(255)), cnt);
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the default size.
    send_word(OP_READ, 8'h00, 7'd5);
    send_word(OP_READ, 8'h00, 7'd0);
    send_word(OP_WRITE, 8'h00, 7'd0);
    send_word(OP_WRITE, 8'hFF, 7'd0);
    send_word(OP_WRITE, 8'h5A, 7'd0);
    send_word(OP_WRITE, 8'hA5, 7'd0);
    send_word(OP_READ, 8'h00, 7'd0);
    send_word(OP_READ, 8'h00, 7'd127);
    send_word(OP_READ, 8'h00, 7'd64);
    send_word(OP_WRITE, 8'h01, 7'd0);
    send_word(OP_WRITE, 8'h80, 7'd0);
    send_word(OP_WRITE, 8'h7E, 7'd0);
    send_word(OP_READ, 8'h00, 7'd1);
    send_word(OP_READ, 8'h00, 7'd64);

    // Smallest ring holds a single byte; the second write finds it full.
    set_ring_size(11'd2);
    send_word(OP_WRITE, 8'h33, 7'd0);
    send_word(OP_WRITE, 8'hCC, 7'd0);
    send_word(OP_READ, 8'h00, 7'd2);
    send_word(OP_READ, 8'h00, 7'd1);

    // Settings below the minimum act as the minimum.
    set_ring_size(11'd0);
    send_word(OP_WRITE, 8'h96, 7'd0);
    send_word(OP_WRITE, 8'h69, 7'd0);
    send_word(OP_READ, 8'h00, 7'd100);
    set_ring_size(11'd1);
    send_word(OP_WRITE, 8'hC3, 7'd0);
    send_word(OP_WRITE, 8'h3C, 7'd0);
    send_word(OP_READ, 8'h00, 7'd1);

    // Settings above the store depth act as the full store.
    set_ring_size(11'h7FF);
    send_word(OP_WRITE, 8'hE7, 7'd0);
    send_word(OP_READ, 8'h00, 7'd3);

    run_phase(22, 11'd3);
    run_phase(22, RING_SIZE_W'($urandom_range(40, 4)));
    run_phase(54, 11'd2);
    run_phase(54, 11'd1024);
    run_phase(0, 11'd17);
    run_phase(0, RING_SIZE_W'($urandom_range(1024, 41)));

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_byte_ring_fifo: PASS");
    end else begin
      $display("tb_byte_ring_fifo: FAIL");
    end
    $finish;
  end

endmodule
